// ===== rtl/avlc_header_decode_station_table_defines.svh =====
// ----------------------------------------------------------------------------
// avlc header decode assertion macros
// shared concurrent assertion forms for the checker of the header decoder
// ----------------------------------------------------------------------------
`ifndef AVLC_HEADER_DECODE_STATION_TABLE_DEFINES_SVH
`define AVLC_HEADER_DECODE_STATION_TABLE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define AVLC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AVLC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/avlc_pkg.sv =====
// ----------------------------------------------------------------------------
// avlc_pkg
// shared types and constants of the frame header decoder and station table
// ----------------------------------------------------------------------------
package avlc_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int TBL_IDX_W   = $clog2(TABLE_DEPTH);
  localparam int TBL_CNT_W   = $clog2(TABLE_DEPTH + 1);

  localparam int IN_DATA_W   = 120;
  localparam int OUT_DATA_W  = 88;
  localparam int OUT_USER_W  = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [15:0] AGE_LIMIT_RESET = 16'd1800;
  localparam logic [23:0] ICAO_ALL_ONES   = 24'hffffff;
  localparam logic [12:0] EMPTY_LEN_MAX   = 13'd13;
  localparam logic [2:0]  ADDR_TYPE_AIR   = 3'd1;
  localparam logic [15:0] COUNT_MAX       = 16'hffff;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_GROUND   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_EMPTY    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_BAD_ADDR = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_AGE_LIMIT       = 2'd3;

  // link control frame kinds
  localparam logic [1:0] KIND_I = 2'd0;
  localparam logic [1:0] KIND_S = 2'd1;
  localparam logic [1:0] KIND_U = 2'd2;

  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] rx_seconds;
    logic [12:0] frame_length;
    logic [7:0]  link_control;
    logic [31:0] src_header;
    logic [31:0] dst_header;
  } in_data_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic        table_full;
    logic        new_aircraft;
    logic [15:0] msg_count;
    logic [4:0]  sub_code;
    logic [2:0]  recv_seq;
    logic [2:0]  send_seq;
    logic        on_ground;
    logic        resp_flag;
    logic [26:0] dst_addr;
    logic [26:0] src_addr;
  } out_data_t;

  typedef struct packed {
    logic [1:0] frame_kind;
    logic       accepted;
  } out_user_t;

  typedef struct packed {
    logic        accept_ground;
    logic        accept_empty;
    logic        accept_bad_addr;
    logic [15:0] age_limit_s;
  } cfg_t;

  typedef struct packed {
    logic        accepted;
    logic        from_air;
    logic [23:0] icao;
    logic [26:0] src_addr;
    logic [26:0] dst_addr;
    logic        resp_flag;
    logic        on_ground;
    logic [1:0]  frame_kind;
    logic [2:0]  send_seq;
    logic [2:0]  recv_seq;
    logic [4:0]  sub_code;
  } hdr_dec_t;

  typedef struct packed {
    logic        start;
    logic [23:0] icao;
    logic [31:0] now;
    logic [15:0] age_limit;
  } tbl_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] msg_count;
    logic        new_aircraft;
    logic        table_full;
  } tbl_rsp_t;

  typedef struct packed {
    logic [23:0] addr;
    logic [31:0] last_seen;
    logic [15:0] count;
  } entry_t;

endpackage

// ===== rtl/avlc_header_decode_station_table.sv =====
// ----------------------------------------------------------------------------
// avlc_header_decode_station_table
// frame header decoder with a bounded table of aircraft stations
// ----------------------------------------------------------------------------
// One frame header enters per input transfer and leaves as exactly one result
// transfer, in order. Frames that are dropped or whose source is not an
// aircraft go from ST_RUN straight to ST_DONE and into the output register.
// An accepted aircraft frame waits in ST_WAIT while the station table is
// swept once through its single read port, one entry a cycle, checking the
// address match, expiry and the lowest free entry; the entry is then written
// back unless the table is full, and the result goes through ST_DONE into the
// output register. A stalled output keeps the frame in ST_DONE. One frame
// is processed at a time; the next input is taken as soon as the previous
// result sits in the output register. Valid bits reset with the block, so the
// table needs no clearing pass. The configuration port is always ready and is
// meant to be written only while the block is idle.
module avlc_header_decode_station_table (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // dst_header, src_header, link_control, frame_length, rx_seconds, zero pad
  input  logic [avlc_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // src_addr, dst_addr, resp_flag, on_ground, send_seq, recv_seq, sub_code,
  // msg_count, new_aircraft, table_full, zero pad
  output logic [avlc_pkg::OUT_DATA_W-1:0]      m_tdata,
  // accepted, frame_kind
  output logic [avlc_pkg::OUT_USER_W-1:0]      m_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [avlc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [avlc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import avlc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t    state;
  cfg_t      cfg;
  in_data_t  in_reg;
  hdr_dec_t  dec;
  tbl_req_t  req;
  tbl_rsp_t  rsp;
  logic      need_tbl;
  logic      out_load;
  out_data_t out_data;
  out_user_t out_user;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accept_ground   <= 1'b0;
      cfg.accept_empty    <= 1'b0;
      cfg.accept_bad_addr <= 1'b0;
      cfg.age_limit_s     <= AGE_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ACCEPT_GROUND:   cfg.accept_ground   <= cfg_data[0];
        CFG_ACCEPT_EMPTY:    cfg.accept_empty    <= cfg_data[0];
        CFG_ACCEPT_BAD_ADDR: cfg.accept_bad_addr <= cfg_data[0];
        CFG_AGE_LIMIT:       cfg.age_limit_s     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  avlc_hdr_decode u_dec (
    .hdr (in_reg),
    .cfg (cfg),
    .dec (dec)
  );

  assign need_tbl = dec.accepted && dec.from_air;

  assign req = '{start: (state == ST_RUN) && need_tbl, icao: dec.icao,
                 now: in_reg.rx_seconds, age_limit: cfg.age_limit_s};

  avlc_station_table u_tbl (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          state <= need_tbl ? ST_WAIT : ST_DONE;
        end
        ST_WAIT: begin
          if (rsp.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_reg <= in_data_t'(s_tdata);
    end
  end

  // table fields stay zero unless the frame went through the table
  always_comb begin
    out_data              = '0;
    out_data.src_addr     = dec.src_addr;
    out_data.dst_addr     = dec.dst_addr;
    out_data.resp_flag    = dec.resp_flag;
    out_data.on_ground    = dec.on_ground;
    out_data.send_seq     = dec.send_seq;
    out_data.recv_seq     = dec.recv_seq;
    out_data.sub_code     = dec.sub_code;
    if (need_tbl) begin
      out_data.msg_count    = rsp.msg_count;
      out_data.new_aircraft = rsp.new_aircraft;
      out_data.table_full   = rsp.table_full;
    end
    out_user.accepted   = dec.accepted;
    out_user.frame_kind = dec.frame_kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_data;
      m_tuser <= out_user;
    end
  end

endmodule

// ===== rtl/avlc_hdr_decode.sv =====
// ----------------------------------------------------------------------------
// avlc_hdr_decode
// address rebuild, filter flags and link control decode of one frame header
// ----------------------------------------------------------------------------
module avlc_hdr_decode (
  input  avlc_pkg::in_data_t hdr,
  input  avlc_pkg::cfg_t     cfg,
  output avlc_pkg::hdr_dec_t dec
);
  import avlc_pkg::*;

  // each header byte carries its address bits reversed, bit 0 is the extension bit
  function automatic logic [26:0] rebuild_addr(input logic [31:0] w);
    logic [26:0] r;
    r = '0;
    for (int i = 0; i < 6; i++) begin
      r[26-i] = w[26+i];
    end
    for (int i = 0; i < 7; i++) begin
      r[20-i] = w[17+i];
      r[13-i] = w[9+i];
      r[6-i]  = w[1+i];
    end
    return r;
  endfunction

  logic [26:0] faddr;
  logic [7:0]  lc;
  logic        from_air;
  logic [23:0] icao;
  logic        bad_addr;

  assign faddr    = rebuild_addr(hdr.src_header);
  assign lc       = hdr.link_control;
  assign from_air = (faddr[26:24] == ADDR_TYPE_AIR);
  assign icao     = faddr[23:0];
  assign bad_addr = (icao == 24'd0) || (icao == ICAO_ALL_ONES);

  always_comb begin
    dec             = '0;
    dec.src_addr    = faddr;
    dec.dst_addr    = rebuild_addr(hdr.dst_header);
    dec.icao        = icao;
    dec.from_air    = from_air;
    dec.resp_flag   = hdr.src_header[25];
    dec.on_ground   = hdr.dst_header[25];
    dec.accepted    = !(!cfg.accept_ground && !from_air) &&
                      !(!cfg.accept_empty && (hdr.frame_length <= EMPTY_LEN_MAX)) &&
                      !(!cfg.accept_bad_addr && from_air && bad_addr);
    if (lc[0]) begin
      if (lc[1]) begin
        dec.frame_kind = KIND_U;
        dec.sub_code   = {lc[7:5], lc[3:2]};
      end else begin
        dec.frame_kind = KIND_S;
        dec.recv_seq   = lc[7:5];
        dec.sub_code   = {3'b000, lc[3:2]};
      end
    end else begin
      dec.frame_kind = KIND_I;
      dec.send_seq   = lc[3:1];
      dec.recv_seq   = lc[7:5];
    end
  end

endmodule

// ===== rtl/avlc_station_table.sv =====
// ----------------------------------------------------------------------------
// avlc_station_table
// station table in a synchronous memory, swept once per aircraft frame for
// match, expiry and the lowest free entry, then at most one write back
// ----------------------------------------------------------------------------
module avlc_station_table (
  input  logic               clk,
  input  logic               rst,
  input  avlc_pkg::tbl_req_t req,
  output avlc_pkg::tbl_rsp_t rsp
);
  import avlc_pkg::*;

  typedef enum logic [2:0] {
    TS_IDLE  = 3'b001,
    TS_SWEEP = 3'b010,
    TS_WRITE = 3'b100
  } tstate_t;

  tstate_t state;

  entry_t                 mem [TABLE_DEPTH];
  entry_t                 rd_data;
  logic [TABLE_DEPTH-1:0] valid;

  logic [TBL_CNT_W-1:0] rd_cnt;
  logic [TBL_IDX_W-1:0] rd_idx;
  logic [TBL_IDX_W-1:0] chk_idx;
  logic                 chk_vld;

  logic                 hit;
  logic [TBL_IDX_W-1:0] hit_idx;
  logic [15:0]          hit_count;
  logic                 free_found;
  logic [TBL_IDX_W-1:0] free_idx;

  logic        chk_valid_bit;
  logic        match;
  logic [31:0] age;
  logic        expired;
  logic        is_free;
  logic        last_chk;
  logic [15:0] new_count;
  logic        we;
  logic [TBL_IDX_W-1:0] wa;
  entry_t      wd;

  logic        done;
  logic [15:0] msg_count;
  logic        new_aircraft;
  logic        table_full;

  assign rd_idx        = rd_cnt[TBL_IDX_W-1:0];
  assign chk_valid_bit = valid[chk_idx];
  assign match         = chk_vld && chk_valid_bit && (rd_data.addr == req.icao);
  assign age           = req.now - rd_data.last_seen;
  assign expired       = chk_vld && chk_valid_bit && !match &&
                         (age > {16'd0, req.age_limit});
  // an entry expired in this sweep is free for the insertion that follows
  assign is_free       = chk_vld && (!chk_valid_bit || expired);
  assign last_chk      = chk_vld && (chk_idx == TBL_IDX_W'(TABLE_DEPTH - 1));

  assign new_count = !hit ? 16'd1 :
                     (hit_count == COUNT_MAX) ? hit_count : hit_count + 16'd1;
  assign we        = (state == TS_WRITE) && (hit || free_found);
  assign wa        = hit ? hit_idx : free_idx;
  assign wd        = '{addr: req.icao, last_seen: req.now, count: new_count};

  // write back only after the sweep, so no read of the sweep overlaps the write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= TS_IDLE;
      valid      <= '0;
      chk_vld    <= 1'b0;
      done       <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      rd_cnt     <= '0;
    end else begin
      done    <= 1'b0;
      chk_vld <= 1'b0;
      case (state)
        TS_IDLE: begin
          if (req.start) begin
            rd_cnt     <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= TS_SWEEP;
          end
        end
        TS_SWEEP: begin
          if (rd_cnt < TBL_CNT_W'(TABLE_DEPTH)) begin
            chk_vld <= 1'b1;
            chk_idx <= rd_idx;
            rd_cnt  <= rd_cnt + 1'b1;
          end
          if (match) begin
            hit       <= 1'b1;
            hit_idx   <= chk_idx;
            hit_count <= rd_data.count;
          end
          if (expired) begin
            valid[chk_idx] <= 1'b0;
          end
          if (is_free && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= chk_idx;
          end
          if (last_chk) begin
            state <= TS_WRITE;
          end
        end
        TS_WRITE: begin
          if (!hit && free_found) begin
            valid[free_idx] <= 1'b1;
          end
          msg_count    <= new_count;
          new_aircraft <= !hit && free_found;
          table_full   <= !hit && !free_found;
          done         <= 1'b1;
          state        <= TS_IDLE;
        end
        default: begin
          state <= TS_IDLE;
        end
      endcase
    end
  end

  assign rsp = '{done: done, msg_count: msg_count, new_aircraft: new_aircraft,
                 table_full: table_full};

endmodule

// ===== rtl/avlc_checker.sv =====
// ----------------------------------------------------------------------------
// avlc_checker
// port level checks of the frame header decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "avlc_header_decode_station_table_defines.svh"

module avlc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [avlc_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [avlc_pkg::OUT_USER_W-1:0] m_tuser
);
  import avlc_pkg::*;

  out_data_t od;
  out_user_t ou;

  assign od = out_data_t'(m_tdata);
  assign ou = out_user_t'(m_tuser);

  // a stalled result holds
  `AVLC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // one frame in flight: no input transfer right after another
  `AVLC_ASSERT_NEXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready, "input taken while a frame is in flight")

  // dropped frames never touch the table
  `AVLC_ASSERT_SAME(a_drop_clean, clk, rst, m_tvalid && !ou.accepted, (od.msg_count == 16'd0) && !od.new_aircraft && !od.table_full, "dropped frame carries table fields")

  // a new or unstored aircraft has seen exactly one message
  `AVLC_ASSERT_SAME(a_first_msg, clk, rst, m_tvalid && (od.new_aircraft || od.table_full), (od.msg_count == 16'd1) && !(od.new_aircraft && od.table_full), "bad count for new aircraft")

endmodule

bind avlc_header_decode_station_table avlc_checker u_avlc_checker (.*);

// ===== test/avlc_header_decode_station_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avlc_header_decode_station_table_tb
// self-checking bench for the frame header decoder and its station table
// ----------------------------------------------------------------------------
// Frame headers are queued by the stimulus process and sent by a clocked
// driver; a clocked monitor predicts each header as it is taken (address rebuild,
// filters, link-control decode, station lookup, expiry and insertion) and
// checks every result transfer against the oldest prediction. A short
// directed set is followed by eight random phases, each with its own filter
// and age settings, and one of four patterns of sender gaps and receiver stalls.
module avlc_header_decode_station_table_tb;
  import avlc_pkg::*;

  localparam logic [26:0] STN_A = {ADDR_TYPE_AIR, 24'habcdef};
  localparam logic [26:0] STN_B = {ADDR_TYPE_AIR, 24'h123456};
  localparam int POOL_SIZE = 100;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    out_user_t user;
    out_data_t data;
  } hdr_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  in_data_t pending_frames[$];
  hdr_result_t expected_results[$];
  logic [23:0] station_pool[POOL_SIZE];
  logic [31:0] wall_s = 32'd0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit in_fire = 1'b0;

  // predicted configuration and station table
  logic pass_ground = 1'b0;
  logic pass_empty = 1'b0;
  logic pass_bad_addr = 1'b0;
  logic [15:0] age_limit = AGE_LIMIT_RESET;
  logic stn_valid[TABLE_DEPTH];
  logic [23:0] stn_addr[TABLE_DEPTH];
  logic [31:0] stn_seen[TABLE_DEPTH];
  logic [15:0] stn_count[TABLE_DEPTH];

  int errors = 0;
  int frames_in = 0;
  int frames_passed = 0;
  int stations_added = 0;
  int table_refusals = 0;
  int reg_writes = 0;

  avlc_header_decode_station_table uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [6:0] mirror_bits(input logic [6:0] v, input int n);
    logic [6:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r[n-1-i] = v[i];
    return r;
  endfunction

  // address bits sit in the top bits of each header byte, lsb first
  function automatic logic [26:0] unpack_addr(input logic [31:0] w);
    logic [6:0] a, b, c, d;
    a = mirror_bits({1'b0, w[31:26]}, 6);
    b = mirror_bits(w[23:17], 7);
    c = mirror_bits(w[15:9], 7);
    d = mirror_bits(w[7:1], 7);
    return {a[5:0], b, c, d};
  endfunction

  function automatic logic [31:0] pack_addr(input logic [26:0] addr, input logic flag,
                                            input logic [3:0] spare);
    logic [6:0] a, b, c, d;
    a = mirror_bits({1'b0, addr[26:21]}, 6);
    b = mirror_bits(addr[20:14], 7);
    c = mirror_bits(addr[13:7], 7);
    d = mirror_bits(addr[6:0], 7);
    return {a[5:0], flag, spare[0], b, spare[1], c, spare[2], d, spare[3]};
  endfunction

  function automatic in_data_t make_frame(input logic [26:0] src, input logic [26:0] dst,
                                          input logic resp, input logic gnd,
                                          input logic [7:0] lc, input logic [12:0] len,
                                          input logic [31:0] t);
    in_data_t f;
    f = '0;
    f.src_header = pack_addr(src, resp, 4'($urandom));
    f.dst_header = pack_addr(dst, gnd, 4'($urandom));
    f.link_control = lc;
    f.frame_length = len;
    f.rx_seconds = t;
    return f;
  endfunction

  function automatic void predict_header_result(input in_data_t f);
    logic [26:0] from_addr;
    logic [23:0] icao;
    logic [7:0] lc;
    logic [31:0] silent;
    logic air, pass;
    int hit, slot;
    hdr_result_t r;
    r = '0;
    lc = f.link_control;
    from_addr = unpack_addr(f.src_header);
    icao = from_addr[23:0];
    air = (from_addr[26:24] == ADDR_TYPE_AIR);
    r.data.src_addr = from_addr;
    r.data.dst_addr = unpack_addr(f.dst_header);
    r.data.resp_flag = f.src_header[25];
    r.data.on_ground = f.dst_header[25];
    if (lc[0] && lc[1]) begin
      r.user.frame_kind = KIND_U;
      r.data.sub_code = {lc[7:5], lc[3:2]};
    end else if (lc[0]) begin
      r.user.frame_kind = KIND_S;
      r.data.recv_seq = lc[7:5];
      r.data.sub_code = {3'b000, lc[3:2]};
    end else begin
      r.user.frame_kind = KIND_I;
      r.data.send_seq = lc[3:1];
      r.data.recv_seq = lc[7:5];
    end
    pass = 1'b1;
    if (!pass_ground && !air) pass = 1'b0;
    if (!pass_empty && f.frame_length <= EMPTY_LEN_MAX) pass = 1'b0;
    if (!pass_bad_addr && air && (icao == 24'h0 || icao == ICAO_ALL_ONES)) pass = 1'b0;
    r.user.accepted = pass;
    if (pass && air) begin
      hit = -1;
      slot = -1;
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (hit < 0 && stn_valid[i] && stn_addr[i] == icao) hit = i;
      // wrapping age, so a clock that steps back makes entries look ancient
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (i != hit && stn_valid[i]) begin
          silent = f.rx_seconds - stn_seen[i];
          if (silent > {16'h0, age_limit}) stn_valid[i] = 1'b0;
        end
      end
      if (hit >= 0) begin
        stn_seen[hit] = f.rx_seconds;
        if (stn_count[hit] != COUNT_MAX) stn_count[hit] = stn_count[hit] + 16'd1;
        r.data.msg_count = stn_count[hit];
      end else begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (slot < 0 && !stn_valid[i]) slot = i;
        r.data.msg_count = 16'd1;
        if (slot >= 0) begin
          stn_valid[slot] = 1'b1;
          stn_addr[slot] = icao;
          stn_seen[slot] = f.rx_seconds;
          stn_count[slot] = 16'd1;
          r.data.new_aircraft = 1'b1;
          stations_added++;
        end else begin
          r.data.table_full = 1'b1;
          table_refusals++;
        end
      end
    end
    if (pass) frames_passed++;
    expected_results.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // sender: a frame stays on the bus until its transfer
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      in_fire = 1'b0;
      if (pending_frames.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_tdata <= pending_frames.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : result_monitor
    hdr_result_t want;
    out_data_t got_d;
    out_user_t got_u;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          CFG_ACCEPT_GROUND:   pass_ground = cfg_data[0];
          CFG_ACCEPT_EMPTY:    pass_empty = cfg_data[0];
          CFG_ACCEPT_BAD_ADDR: pass_bad_addr = cfg_data[0];
          CFG_AGE_LIMIT:       age_limit = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no frame outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          got_d = m_tdata;
          got_u = m_tuser;
          check_field("accepted", want.user.accepted, got_u.accepted);
          check_field("src_addr", want.data.src_addr, got_d.src_addr);
          check_field("dst_addr", want.data.dst_addr, got_d.dst_addr);
          check_field("resp_flag", want.data.resp_flag, got_d.resp_flag);
          check_field("on_ground", want.data.on_ground, got_d.on_ground);
          check_field("frame_kind", want.user.frame_kind, got_u.frame_kind);
          check_field("send_seq", want.data.send_seq, got_d.send_seq);
          check_field("recv_seq", want.data.recv_seq, got_d.recv_seq);
          check_field("sub_code", want.data.sub_code, got_d.sub_code);
          check_field("msg_count", want.data.msg_count, got_d.msg_count);
          check_field("new_aircraft", want.data.new_aircraft, got_d.new_aircraft);
          check_field("table_full", want.data.table_full, got_d.table_full);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_header_result(in_data_t'(s_tdata));
        frames_in++;
        in_fire = 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_frames.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // mostly well-formed aircraft traffic from a pool of stations; steady
  // phases keep the clock monotonic so the table can fill up
  task automatic queue_random_frames(input int count, input int span, input bit steady);
    in_data_t f;
    logic [26:0] src;
    logic [12:0] len;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 20) begin
        f = '0;
        f.dst_header = $urandom;
        f.src_header = $urandom;
        f.link_control = 8'($urandom);
        f.frame_length = 13'($urandom);
        f.rx_seconds = (!steady && $urandom_range(1) == 1) ? 32'($urandom) : wall_s;
      end else begin
        r = $urandom_range(99);
        if (!steady && r < 3) wall_s = wall_s - 32'($urandom_range(1, 50));
        else if (!steady && r < 6) wall_s = wall_s + 32'($urandom_range(1000, 70000));
        else wall_s = wall_s + 32'($urandom_range(0, 20));
        r = $urandom_range(99);
        if (r < 3) begin
          src = {ADDR_TYPE_AIR, ($urandom_range(1) == 1) ? ICAO_ALL_ONES : 24'h0};
        end else if (r < 18) begin
          src = 27'($urandom);
          if (src[26:24] == ADDR_TYPE_AIR) src[26:24] = 3'd0;
        end else begin
          src = {ADDR_TYPE_AIR, station_pool[$urandom_range(span - 1)]};
        end
        len = ($urandom_range(9) == 0) ? 13'($urandom_range(13)) : 13'($urandom_range(14, 8191));
        f = make_frame(src, 27'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                       len, wall_s);
      end
      pending_frames.push_back(f);
    end
  endtask

  initial begin
    in_data_t f;
    logic g, e, b;
    logic [15:0] age;
    int span;
    for (int i = 0; i < TABLE_DEPTH; i++) stn_valid[i] = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) station_pool[i] = 24'($urandom);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed set under the reset filter settings
    pending_frames.push_back(make_frame(STN_A, 27'($urandom), 1'b0, 1'b0, 8'h00, 13'd100,
                                        32'd1000));
    pending_frames.push_back(make_frame(STN_A, 27'($urandom), 1'b1, 1'b1, 8'hfe, 13'd8191,
                                        32'd1010));
    pending_frames.push_back(make_frame(STN_A, 27'($urandom), 1'b0, 1'b1, 8'h01, 13'd14,
                                        32'd1020));
    pending_frames.push_back(make_frame(STN_A, 27'($urandom), 1'b1, 1'b0, 8'hff, 13'd13,
                                        32'd1030));
    pending_frames.push_back(make_frame(STN_B, 27'($urandom), 1'b0, 1'b0, 8'h03, 13'd0,
                                        32'd1040));
    pending_frames.push_back(make_frame({3'd2, 24'habcdef}, 27'($urandom), 1'b0, 1'b0, 8'hed,
                                        13'd200, 32'd1050));
    pending_frames.push_back(make_frame({ADDR_TYPE_AIR, 24'h0}, 27'($urandom), 1'b0, 1'b0,
                                        8'h21, 13'd200, 32'd1060));
    pending_frames.push_back(make_frame({ADDR_TYPE_AIR, ICAO_ALL_ONES}, 27'($urandom), 1'b0,
                                        1'b0, 8'h42, 13'd200, 32'd1070));
    pending_frames.push_back(make_frame(STN_B, 27'($urandom), 1'b0, 1'b0, 8'he3, 13'd200,
                                        32'd1500));
    // one second past the limit for the first station
    pending_frames.push_back(make_frame(STN_B, 27'($urandom), 1'b0, 1'b0, 8'h05, 13'd200,
                                        32'd2821));
    pending_frames.push_back(make_frame(STN_A, 27'($urandom), 1'b0, 1'b0, 8'h09, 13'd200,
                                        32'd2821));
    // clock steps back
    pending_frames.push_back(make_frame(STN_A, 27'($urandom), 1'b0, 1'b0, 8'h0d, 13'd300,
                                        32'd100));
    f = '0;
    pending_frames.push_back(f);
    f = '1;
    f.pad = '0;
    pending_frames.push_back(f);
    pending_frames.push_back(make_frame(STN_A, 27'($urandom), 1'b1, 1'b1, 8'h63, 13'd64,
                                        32'd110));
    pending_frames.push_back(make_frame(STN_A, 27'($urandom), 1'b0, 1'b1, 8'h8f, 13'd64,
                                        32'd120));
    pending_frames.push_back(make_frame(STN_A, 27'($urandom), 1'b1, 1'b0, 8'h5a, 13'd64,
                                        32'd120));
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin g = 1'b0; e = 1'b0; b = 1'b0; age = 16'd1800;  span = 40;  end
        1: begin g = 1'b1; e = 1'b1; b = 1'b1; age = 16'hffff;  span = 100; end
        2: begin g = 1'b1; e = 1'b0; b = 1'b1; age = 16'd0;     span = 40;  end
        3: begin g = 1'b0; e = 1'b1; b = 1'b0; age = 16'd30;    span = 40;  end
        4: begin g = 1'b1; e = 1'b1; b = 1'b0; age = 16'hffff;  span = 100; end
        5: begin g = 1'b0; e = 1'b0; b = 1'b1; age = 16'd1;     span = 40;  end
        6: begin g = 1'b1; e = 1'b1; b = 1'b1; age = 16'd1800;  span = 100; end
        default: begin g = 1'b0; e = 1'b1; b = 1'b1; age = 16'd600; span = 60; end
      endcase
      write_reg(CFG_ACCEPT_GROUND, {15'd0, g});
      write_reg(CFG_ACCEPT_EMPTY, {15'd0, e});
      write_reg(CFG_ACCEPT_BAD_ADDR, {15'd0, b});
      write_reg(CFG_AGE_LIMIT, age);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
        default: begin src_idle_pct = 32; sink_stall_pct = 32; end
      endcase
      wall_s = $urandom;
      // sender holds off mid-phase until every result is back
      queue_random_frames(115, span, span == 100);
      wait_drained();
      queue_random_frames(115, span, span == 100);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d frames checked, %0d passed the filters, %0d stations added",
             frames_in, frames_passed, stations_added);
    $display("%0d table-full refusals, %0d register writes over eight setting phases",
             table_refusals, reg_writes);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("avlc_header_decode_station_table test passed");
    end else begin
      $display("avlc_header_decode_station_table test failed");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("avlc_header_decode_station_table test failed");
    $finish;
  end

endmodule
